// File: rtl/i2cmra_pkg.sv
// ----------------------------------------------------------------------------
// i2cmra_pkg
// Shared types and constants of the I2C single-register access master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmra_pkg;

  // Bus sequencer phases, one per bus segment
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_TX_LOW    = 4'd3,
    PH_TX_HIGH   = 4'd4,
    PH_TX_TAIL   = 4'd5,
    PH_ACK_LOW   = 4'd6,
    PH_ACK_HIGH  = 4'd7,
    PH_ACK_POLL  = 4'd8,
    PH_RX_LOW    = 4'd9,
    PH_RX_HIGH   = 4'd10,
    PH_NACK_LOW  = 4'd11,
    PH_NACK_HIGH = 4'd12,
    PH_STOP_A    = 4'd13,
    PH_STOP_B    = 4'd14,
    PH_FINISH    = 4'd15
  } phase_t;

  // Which byte of the transaction is being sent or awaiting acknowledge
  typedef enum logic [1:0] {
    STG_ADDR = 2'd0,
    STG_REG  = 2'd1,
    STG_TAIL = 2'd2
  } stage_t;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT    = 2'd1;

  localparam logic [7:0] TPU_RESET         = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

  // One result item of a tick
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_data;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/i2c_master_register_access_core.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access_core
// I2C master for single-register write and read, stepped one bus tick per
// input transfer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | request fields, sampled SDA
//  out_    | output    | out_valid / out_ready  | bus levels, status, read data
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One tick per cycle unless the output stalls: each accepted input transfer
//  steps the sequencer once and its result is in the output register on the
//  next cycle. The sequencer state and the output register are the only stages.
//  Reset (synchronous, active low) returns to idle with the default timing.
//  A stalled output holds the result; input is taken again in the cycle the
//  held result leaves. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_register_access_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_start_request,
  input  wire                               in_mode,
  input  wire  [6:0]                        in_device_address,
  input  wire  [7:0]                        in_register_address,
  input  wire  [7:0]                        in_write_data,
  input  wire                               in_sda_in,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              out_scl,
  output logic                              out_sda_out,
  output logic                              out_sda_drive,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic                              out_ack_error,
  output logic [7:0]                        out_read_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [i2cmra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [7:0]                        cfg_data
);

  i2cmra_pkg::res_t seq_res;
  i2cmra_pkg::res_t out_res;
  logic             can_load;
  logic             step;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load;
  assign step      = in_valid && can_load;

  i2cmra_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .start_request    (in_start_request),
    .mode             (in_mode),
    .device_address   (in_device_address),
    .register_address (in_register_address),
    .write_data       (in_write_data),
    .sda_in           (in_sda_in),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .res              (seq_res)
  );

  i2cmra_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (seq_res),
    .out_ready (out_ready),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_scl       = out_res.scl;
  assign out_sda_out   = out_res.sda_out;
  assign out_sda_drive = out_res.sda_drive;
  assign out_busy_res  = out_res.busy_res;
  assign out_done_res  = out_res.done_res;
  assign out_ack_error = out_res.ack_error;
  assign out_read_data = out_res.read_data;

endmodule

`default_nettype wire

// File: rtl/i2cmra_seq.sv
// ----------------------------------------------------------------------------
// i2cmra_seq
// Bus sequencer: holds the transaction state, steps it once per transfer and
// forms the bus levels of the current phase.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmra_seq (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 step,
  input  wire                                 start_request,
  input  wire                                 mode,
  input  wire  [6:0]                          device_address,
  input  wire  [7:0]                          register_address,
  input  wire  [7:0]                          write_data,
  input  wire                                 sda_in,
  input  wire                                 cfg_we,
  input  wire  [i2cmra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [7:0]                          cfg_data,
  output i2cmra_pkg::res_t                    res
);

  i2cmra_pkg::phase_t phase_r, phase_nxt;
  i2cmra_pkg::stage_t stage_r, stage_nxt;
  logic [9:0] delay_r, delay_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       mode_r, mode_nxt;
  logic [6:0] dev_r, dev_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [7:0] data_r, data_nxt;
  logic [7:0] rxbyte_r, rxbyte_nxt;
  logic       err_r, err_nxt;
  logic [7:0] tpu_r, timeout_r;

  logic [7:0]  tpu_eff;
  logic [9:0]  seg_len;
  logic        seg_end;
  logic [7:0]  shift_samp;
  logic [3:0]  bit_inc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r     <= i2cmra_pkg::TPU_RESET;
      timeout_r <= i2cmra_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == i2cmra_pkg::REG_TICKS_PER_UNIT) tpu_r <= cfg_data;
      if (cfg_index == i2cmra_pkg::REG_ACK_TIMEOUT)    timeout_r <= cfg_data;
    end
  end

  // Segment length: units of 1, 2 or 4 scaled by ticks per unit
  assign tpu_eff = (tpu_r == 8'd0) ? 8'd1 : tpu_r;

  always_comb begin
    case (phase_r)
      i2cmra_pkg::PH_START_A, i2cmra_pkg::PH_START_B,
      i2cmra_pkg::PH_STOP_A,  i2cmra_pkg::PH_STOP_B:
        seg_len = {tpu_eff, 2'b00};
      i2cmra_pkg::PH_ACK_LOW, i2cmra_pkg::PH_ACK_HIGH,
      i2cmra_pkg::PH_RX_HIGH:
        seg_len = {2'b00, tpu_eff};
      i2cmra_pkg::PH_TX_LOW,  i2cmra_pkg::PH_TX_HIGH, i2cmra_pkg::PH_TX_TAIL,
      i2cmra_pkg::PH_RX_LOW,  i2cmra_pkg::PH_NACK_LOW, i2cmra_pkg::PH_NACK_HIGH:
        seg_len = {1'b0, tpu_eff, 1'b0};
      default:
        seg_len = 10'd0;
    endcase
  end

  // The segment also ends early when a shorter length was written mid-segment
  assign seg_end    = ({1'b0, delay_r} + 11'd1) >= {1'b0, seg_len};
  assign shift_samp = (phase_r == i2cmra_pkg::PH_RX_HIGH && delay_r == 10'd0) ?
                      {shift_r[6:0], sda_in} : shift_r;
  assign bit_inc    = bit_r + 4'd1;

  // Next state of the sequencer
  always_comb begin
    phase_nxt  = phase_r;
    stage_nxt  = stage_r;
    delay_nxt  = delay_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    poll_nxt   = poll_r;
    mode_nxt   = mode_r;
    dev_nxt    = dev_r;
    reg_nxt    = reg_r;
    data_nxt   = data_r;
    rxbyte_nxt = rxbyte_r;
    err_nxt    = err_r;
    if (step) begin
      unique case (phase_r)
        i2cmra_pkg::PH_IDLE: begin
          if (start_request) begin
            mode_nxt  = mode;
            dev_nxt   = device_address;
            reg_nxt   = register_address;
            data_nxt  = write_data;
            err_nxt   = 1'b0;
            stage_nxt = i2cmra_pkg::STG_ADDR;
            poll_nxt  = 8'd0;
            delay_nxt = 10'd0;
            phase_nxt = i2cmra_pkg::PH_START_A;
          end
        end
        i2cmra_pkg::PH_FINISH: begin
          phase_nxt = i2cmra_pkg::PH_IDLE;
          delay_nxt = 10'd0;
        end
        i2cmra_pkg::PH_ACK_POLL: begin
          delay_nxt = 10'd0;
          if (!sda_in) begin
            // Acknowledge seen: pick the next byte of the transaction
            unique case (stage_r)
              i2cmra_pkg::STG_ADDR: begin
                stage_nxt = i2cmra_pkg::STG_REG;
                shift_nxt = reg_r;
                bit_nxt   = 4'd0;
                phase_nxt = i2cmra_pkg::PH_TX_LOW;
              end
              i2cmra_pkg::STG_REG: begin
                stage_nxt = i2cmra_pkg::STG_TAIL;
                if (mode_r) begin
                  phase_nxt = i2cmra_pkg::PH_START_A;
                end else begin
                  shift_nxt = data_r;
                  bit_nxt   = 4'd0;
                  phase_nxt = i2cmra_pkg::PH_TX_LOW;
                end
              end
              default: begin
                if (mode_r) begin
                  shift_nxt = 8'd0;
                  bit_nxt   = 4'd0;
                  phase_nxt = i2cmra_pkg::PH_RX_LOW;
                end else begin
                  phase_nxt = i2cmra_pkg::PH_STOP_A;
                end
              end
            endcase
          end else if (poll_r >= timeout_r) begin
            err_nxt   = 1'b1;
            phase_nxt = i2cmra_pkg::PH_STOP_A;
          end else begin
            poll_nxt = poll_r + 8'd1;
          end
        end
        default: begin
          // Timed bus segment
          shift_nxt = shift_samp;
          if (!seg_end) begin
            delay_nxt = delay_r + 10'd1;
          end else begin
            delay_nxt = 10'd0;
            unique case (phase_r)
              i2cmra_pkg::PH_START_A: phase_nxt = i2cmra_pkg::PH_START_B;
              i2cmra_pkg::PH_START_B: begin
                shift_nxt = {dev_r, (stage_r == i2cmra_pkg::STG_TAIL)};
                bit_nxt   = 4'd0;
                phase_nxt = i2cmra_pkg::PH_TX_LOW;
              end
              i2cmra_pkg::PH_TX_LOW:  phase_nxt = i2cmra_pkg::PH_TX_HIGH;
              i2cmra_pkg::PH_TX_HIGH: phase_nxt = i2cmra_pkg::PH_TX_TAIL;
              i2cmra_pkg::PH_TX_TAIL: begin
                shift_nxt = {shift_r[6:0], 1'b0};
                bit_nxt   = bit_inc;
                if (bit_inc[3]) begin
                  poll_nxt  = 8'd0;
                  phase_nxt = i2cmra_pkg::PH_ACK_LOW;
                end else begin
                  phase_nxt = i2cmra_pkg::PH_TX_LOW;
                end
              end
              i2cmra_pkg::PH_ACK_LOW: phase_nxt = i2cmra_pkg::PH_ACK_HIGH;
              i2cmra_pkg::PH_ACK_HIGH: begin
                poll_nxt  = 8'd0;
                phase_nxt = i2cmra_pkg::PH_ACK_POLL;
              end
              i2cmra_pkg::PH_RX_LOW: phase_nxt = i2cmra_pkg::PH_RX_HIGH;
              i2cmra_pkg::PH_RX_HIGH: begin
                bit_nxt = bit_inc;
                if (bit_inc[3]) begin
                  rxbyte_nxt = shift_samp;
                  phase_nxt  = i2cmra_pkg::PH_NACK_LOW;
                end else begin
                  phase_nxt  = i2cmra_pkg::PH_RX_LOW;
                end
              end
              i2cmra_pkg::PH_NACK_LOW:  phase_nxt = i2cmra_pkg::PH_NACK_HIGH;
              i2cmra_pkg::PH_NACK_HIGH: phase_nxt = i2cmra_pkg::PH_STOP_A;
              i2cmra_pkg::PH_STOP_A:    phase_nxt = i2cmra_pkg::PH_STOP_B;
              default:                  phase_nxt = i2cmra_pkg::PH_FINISH;
            endcase
          end
        end
      endcase
    end
  end

  // Bus levels and status of the current phase
  always_comb begin
    res.busy_res  = 1'b1;
    res.done_res  = 1'b0;
    res.read_data = rxbyte_r;
    unique case (phase_r)
      i2cmra_pkg::PH_IDLE: begin
        res.scl = 1'b1; res.sda_out = 1'b1; res.sda_drive = 1'b1;
        res.busy_res = 1'b0;
      end
      i2cmra_pkg::PH_FINISH: begin
        res.scl = 1'b1; res.sda_out = 1'b1; res.sda_drive = 1'b1;
        res.busy_res = 1'b0;
        res.done_res = 1'b1;
      end
      i2cmra_pkg::PH_START_A, i2cmra_pkg::PH_NACK_HIGH, i2cmra_pkg::PH_STOP_B: begin
        res.scl = 1'b1; res.sda_out = 1'b1; res.sda_drive = 1'b1;
      end
      i2cmra_pkg::PH_START_B: begin
        res.scl = 1'b1; res.sda_out = 1'b0; res.sda_drive = 1'b1;
      end
      i2cmra_pkg::PH_TX_LOW, i2cmra_pkg::PH_TX_TAIL: begin
        res.scl = 1'b0; res.sda_out = shift_r[7]; res.sda_drive = 1'b1;
      end
      i2cmra_pkg::PH_TX_HIGH: begin
        res.scl = 1'b1; res.sda_out = shift_r[7]; res.sda_drive = 1'b1;
      end
      i2cmra_pkg::PH_ACK_LOW, i2cmra_pkg::PH_RX_LOW: begin
        res.scl = 1'b0; res.sda_out = 1'b0; res.sda_drive = 1'b0;
      end
      i2cmra_pkg::PH_ACK_HIGH, i2cmra_pkg::PH_ACK_POLL, i2cmra_pkg::PH_RX_HIGH: begin
        res.scl = 1'b1; res.sda_out = 1'b0; res.sda_drive = 1'b0;
      end
      i2cmra_pkg::PH_NACK_LOW: begin
        res.scl = 1'b0; res.sda_out = 1'b1; res.sda_drive = 1'b1;
      end
      default: begin
        // Stop setup: clock low, data low
        res.scl = 1'b0; res.sda_out = 1'b0; res.sda_drive = 1'b1;
      end
    endcase
    res.ack_error = res.done_res & err_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= i2cmra_pkg::PH_IDLE;
      stage_r  <= i2cmra_pkg::STG_ADDR;
      delay_r  <= 10'd0;
      bit_r    <= 4'd0;
      poll_r   <= 8'd0;
      err_r    <= 1'b0;
      shift_r  <= 8'd0;
      rxbyte_r <= 8'd0;
      mode_r   <= 1'b0;
      dev_r    <= 7'd0;
      reg_r    <= 8'd0;
      data_r   <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      stage_r  <= stage_nxt;
      delay_r  <= delay_nxt;
      bit_r    <= bit_nxt;
      poll_r   <= poll_nxt;
      err_r    <= err_nxt;
      shift_r  <= shift_nxt;
      rxbyte_r <= rxbyte_nxt;
      mode_r   <= mode_nxt;
      dev_r    <= dev_nxt;
      reg_r    <= reg_nxt;
      data_r   <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2cmra_obuf.sv
// ----------------------------------------------------------------------------
// i2cmra_obuf
// Result register with valid/ready handshake; frees itself on the same cycle
// the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmra_obuf (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    load,
  input  wire i2cmra_pkg::res_t  res,
  input  wire                    out_ready,
  output logic                   can_load,
  output logic                   out_valid,
  output i2cmra_pkg::res_t       out_res
);

  logic             valid_r, valid_nxt;
  i2cmra_pkg::res_t res_r;

  // Accept a new result when empty or when the held one leaves now
  assign can_load = !valid_r || out_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// File: rtl/i2cmra_checker.sv
// ----------------------------------------------------------------------------
// i2cmra_checker
// Port-level checks of the I2C register access master, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmra_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       out_scl,
  input wire       out_sda_out,
  input wire       out_sda_drive,
  input wire       out_busy_res,
  input wire       out_done_res,
  input wire       out_ack_error,
  input wire [7:0] out_read_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_done_res)
      && $stable(out_read_data) && $stable(out_scl))
    else $error("stalled result changed");

  // Input backs off only behind a stalled result
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // Error only reported with done, and done is never busy
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_ack_error || out_done_res) |-> out_done_res && !out_busy_res)
    else $error("bad done/error status");

  // Bus is released high at the end of a transaction
  a_done_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_scl && out_sda_out && out_sda_drive)
    else $error("bus not idle at done");

endmodule

bind i2c_master_register_access_core i2cmra_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_scl       (out_scl),
  .out_sda_out   (out_sda_out),
  .out_sda_drive (out_sda_drive),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_ack_error (out_ack_error),
  .out_read_data (out_read_data)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C single-register access master. Every
// accepted tick is run through a cycle-true model of the bus sequencer, and
// each output transfer is compared field by field with the oldest predicted
// bus level set. The stimulus plays a slave whose acknowledge behavior varies
// per transaction, and the run steps through several timing settings with
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmra_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int DIRECTED_TICKS = 20;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_CYCLES  = 8;

  // Unmapped register slots, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // One input tick
  typedef struct packed {
    logic       start_request;
    logic       mode;
    logic [6:0] dev;
    logic [7:0] reg_addr;
    logic [7:0] data;
    logic       sda;
  } tick_t;

  // How the emulated slave answers acknowledge polls
  typedef enum int {SLV_PROMPT, SLV_SLOW, SLV_ABSENT} slave_kind_t;

  // Bus sequencer model plus the queue of predicted bus levels
  class bus_level_tracker;
    phase_t     ph;
    stage_t     stg;
    logic [9:0] dly;
    logic [3:0] bit_idx;
    logic [7:0] shreg;
    logic [7:0] polls;
    logic [7:0] rx_byte;
    logic       err;
    logic       mode_l;
    logic [6:0] dev_l;
    logic [7:0] reg_l;
    logic [7:0] data_l;
    logic [7:0] tpu;
    logic [7:0] ack_to;
    res_t       pending_levels[$];
    int         mismatches;
    int         ticks;
    int         writes;
    int         reads;
    int         timeouts;

    function new();
      ph = PH_IDLE;
      stg = STG_ADDR;
      dly = '0;
      bit_idx = '0;
      shreg = '0;
      polls = '0;
      rx_byte = '0;
      err = 1'b0;
      {mode_l, dev_l, reg_l, data_l} = '0;
      tpu = TPU_RESET;
      ack_to = ACK_TIMEOUT_RESET;
      mismatches = 0;
      ticks = 0;
      writes = 0;
      reads = 0;
      timeouts = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == REG_TICKS_PER_UNIT) tpu = val;
      else if (idx == REG_ACK_TIMEOUT) ack_to = val;
    endfunction

    function void load_tx(logic [7:0] b);
      shreg = b;
      bit_idx = '0;
      ph = PH_TX_LOW;
    endfunction

    // Predict the levels shown for this tick, then advance one tick
    function void take_tick(tick_t t);
      res_t want;
      int   units;
      int   len;
      int   tpu_eff;
      units = 0;
      case (ph)
        PH_START_A:   begin {want.scl, want.sda_out, want.sda_drive} = 3'b111; units = 4; end
        PH_START_B:   begin {want.scl, want.sda_out, want.sda_drive} = 3'b101; units = 4; end
        PH_TX_LOW: begin
          {want.scl, want.sda_out, want.sda_drive} = {1'b0, shreg[7], 1'b1};
          units = 2;
        end
        PH_TX_HIGH: begin
          {want.scl, want.sda_out, want.sda_drive} = {1'b1, shreg[7], 1'b1};
          units = 2;
        end
        PH_TX_TAIL: begin
          {want.scl, want.sda_out, want.sda_drive} = {1'b0, shreg[7], 1'b1};
          units = 2;
        end
        PH_ACK_LOW:   begin {want.scl, want.sda_out, want.sda_drive} = 3'b000; units = 1; end
        PH_ACK_HIGH:  begin {want.scl, want.sda_out, want.sda_drive} = 3'b100; units = 1; end
        PH_ACK_POLL:  begin {want.scl, want.sda_out, want.sda_drive} = 3'b100; end
        PH_RX_LOW:    begin {want.scl, want.sda_out, want.sda_drive} = 3'b000; units = 2; end
        PH_RX_HIGH:   begin {want.scl, want.sda_out, want.sda_drive} = 3'b100; units = 1; end
        PH_NACK_LOW:  begin {want.scl, want.sda_out, want.sda_drive} = 3'b011; units = 2; end
        PH_NACK_HIGH: begin {want.scl, want.sda_out, want.sda_drive} = 3'b111; units = 2; end
        PH_STOP_A:    begin {want.scl, want.sda_out, want.sda_drive} = 3'b001; units = 4; end
        PH_STOP_B:    begin {want.scl, want.sda_out, want.sda_drive} = 3'b111; units = 4; end
        default:      begin {want.scl, want.sda_out, want.sda_drive} = 3'b111; end
      endcase
      want.busy_res  = (ph != PH_IDLE) && (ph != PH_FINISH);
      want.done_res  = (ph == PH_FINISH);
      want.ack_error = want.done_res & err;
      want.read_data = rx_byte;
      pending_levels.push_back(want);
      ticks++;

      // Idle: latch a request
      if (ph == PH_IDLE) begin
        if (t.start_request) begin
          {mode_l, dev_l, reg_l, data_l} = {t.mode, t.dev, t.reg_addr, t.data};
          err = 1'b0;
          stg = STG_ADDR;
          polls = '0;
          dly = '0;
          ph = PH_START_A;
          if (t.mode) reads++;
          else writes++;
        end
        return;
      end

      // Done tick: drop back to idle
      if (ph == PH_FINISH) begin
        if (err) timeouts++;
        ph = PH_IDLE;
        dly = '0;
        return;
      end

      // Acknowledge poll: advance on low SDA, abort once the budget is spent
      if (ph == PH_ACK_POLL) begin
        dly = '0;
        if (!t.sda) begin
          if (stg == STG_ADDR) begin
            stg = STG_REG;
            load_tx(reg_l);
          end else if (stg == STG_REG) begin
            stg = STG_TAIL;
            if (mode_l) ph = PH_START_A;
            else load_tx(data_l);
          end else if (mode_l) begin
            shreg = '0;
            bit_idx = '0;
            ph = PH_RX_LOW;
          end else begin
            ph = PH_STOP_A;
          end
        end else if (polls >= ack_to) begin
          err = 1'b1;
          ph = PH_STOP_A;
        end else begin
          polls = polls + 8'd1;
        end
        return;
      end

      // Sample SDA on the first tick of a read high segment
      if (ph == PH_RX_HIGH && dly == '0) shreg = {shreg[6:0], t.sda};

      tpu_eff = (tpu == '0) ? 1 : int'(tpu);
      len = units * tpu_eff;
      if (int'(dly) + 1 < len) begin
        dly = dly + 10'd1;
        return;
      end
      dly = '0;
      case (ph)
        PH_START_A:   ph = PH_START_B;
        PH_START_B:   load_tx({dev_l, stg == STG_TAIL});
        PH_TX_LOW:    ph = PH_TX_HIGH;
        PH_TX_HIGH:   ph = PH_TX_TAIL;
        PH_TX_TAIL: begin
          shreg = {shreg[6:0], 1'b0};
          bit_idx = bit_idx + 4'd1;
          if (bit_idx >= 4'd8) begin
            polls = '0;
            ph = PH_ACK_LOW;
          end else begin
            ph = PH_TX_LOW;
          end
        end
        PH_ACK_LOW:   ph = PH_ACK_HIGH;
        PH_ACK_HIGH: begin
          polls = '0;
          ph = PH_ACK_POLL;
        end
        PH_RX_LOW:    ph = PH_RX_HIGH;
        PH_RX_HIGH: begin
          bit_idx = bit_idx + 4'd1;
          if (bit_idx >= 4'd8) begin
            rx_byte = shreg;
            ph = PH_NACK_LOW;
          end else begin
            ph = PH_RX_LOW;
          end
        end
        PH_NACK_LOW:  ph = PH_NACK_HIGH;
        PH_NACK_HIGH: ph = PH_STOP_A;
        PH_STOP_A:    ph = PH_STOP_B;
        default:      ph = PH_FINISH;
      endcase
    endfunction

    function void diff_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    // Compare one output transfer with the oldest prediction
    function void match_levels(res_t got);
      res_t want;
      if (pending_levels.size() == 0) begin
        mismatches++;
        $display("%0t: output transfer with nothing expected, got %h", $time, got);
        return;
      end
      want = pending_levels.pop_front();
      diff_field("scl", {7'd0, want.scl}, {7'd0, got.scl});
      diff_field("sda_out", {7'd0, want.sda_out}, {7'd0, got.sda_out});
      diff_field("sda_drive", {7'd0, want.sda_drive}, {7'd0, got.sda_drive});
      diff_field("busy_res", {7'd0, want.busy_res}, {7'd0, got.busy_res});
      diff_field("done_res", {7'd0, want.done_res}, {7'd0, got.done_res});
      diff_field("ack_error", {7'd0, want.ack_error}, {7'd0, got.ack_error});
      diff_field("read_data", want.read_data, got.read_data);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_start_request = 1'b0;
  logic                 in_mode = 1'b0;
  logic [6:0]           in_device_address = '0;
  logic [7:0]           in_register_address = '0;
  logic [7:0]           in_write_data = '0;
  logic                 in_sda_in = 1'b1;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_scl;
  logic                 out_sda_out;
  logic                 out_sda_drive;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic                 out_ack_error;
  logic [7:0]           out_read_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  bus_level_tracker sb = new();
  slave_kind_t      slave_kind = SLV_PROMPT;
  int               items_sent = 0;
  int               rx_stall_pct = 0;
  int               hold_token = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  int               cycles = 0;

  i2c_master_register_access_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_start_request    (in_start_request),
    .in_mode             (in_mode),
    .in_device_address   (in_device_address),
    .in_register_address (in_register_address),
    .in_write_data       (in_write_data),
    .in_sda_in           (in_sda_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_scl             (out_scl),
    .out_sda_out         (out_sda_out),
    .out_sda_drive       (out_sda_drive),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_ack_error       (out_ack_error),
    .out_read_data       (out_read_data),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, sb.pending_levels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stall the result channel, check every output transfer
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
    if (rst_n && out_valid && out_ready)
      sb.match_levels({out_scl, out_sda_out, out_sda_drive, out_busy_res,
                       out_done_res, out_ack_error, out_read_data});
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Build the next tick from the state the block will be in when it takes it
  function automatic tick_t next_tick();
    tick_t t;
    int    k;
    k = items_sent;
    t.start_request = 1'($urandom_range(1));
    t.mode = 1'($urandom_range(1));
    t.dev = 7'(pick_byte() >> 1);
    t.reg_addr = pick_byte();
    t.data = pick_byte();
    t.sda = 1'($urandom_range(1));
    if (k < DIRECTED_TICKS) begin
      // Ignored idle ticks, an all-ones read, then requests while busy
      if (k == 0) t = {1'b0, 1'b1, 7'h7F, 8'hFF, 8'hFF, 1'b1};
      else if (k == 1) t = '0;
      else if (k == 2) t = {1'b1, 1'b1, 7'h7F, 8'hFF, 8'hFF, 1'b1};
      else t = {1'b1, 1'b0, 7'h00, 8'h00, 8'h00, k[0]};
    end else if ($urandom_range(99) >= 10) begin
      // Well-formed traffic: sparse requests, slave answers acknowledge polls
      if (sb.ph == PH_IDLE) t.start_request = ($urandom_range(99) < 40);
      else t.start_request = ($urandom_range(99) < 15);
      if (sb.ph == PH_ACK_POLL) begin
        case (slave_kind)
          SLV_PROMPT: t.sda = ($urandom_range(99) < 15);
          SLV_SLOW:   t.sda = ($urandom_range(99) < 75);
          default:    t.sda = 1'b1;
        endcase
      end
    end
    if (sb.ph == PH_IDLE && t.start_request) begin
      case ($urandom_range(9))
        0:       slave_kind = SLV_ABSENT;
        1, 2:    slave_kind = SLV_SLOW;
        default: slave_kind = SLV_PROMPT;
      endcase
    end
    return t;
  endfunction

  // Offer ticks with random sender gaps until count transfers are done
  task automatic send_items(int count, int idle_pct);
    tick_t cur;
    bit    holding;
    int    sent;
    cur = '0;
    holding = 1'b0;
    sent = 0;
    while (sent < count) begin
      @(posedge clk);
      if (in_valid && in_ready) begin
        sb.take_tick(cur);
        sent++;
        items_sent++;
        holding = 1'b0;
      end
      if (!holding && sent < count && $urandom_range(99) >= idle_pct) begin
        cur = next_tick();
        in_start_request    <= cur.start_request;
        in_mode             <= cur.mode;
        in_device_address   <= cur.dev;
        in_register_address <= cur.reg_addr;
        in_write_data       <= cur.data;
        in_sda_in           <= cur.sda;
        holding = 1'b1;
      end
      in_valid <= holding;
    end
  endtask

  // Write one register once every predicted result has left the block
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    while (sb.pending_levels.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] tpu_val, logic [7:0] to_val, int idle_pct,
                           int stall_pct, bit hold, int count);
    write_reg(REG_TICKS_PER_UNIT, tpu_val);
    write_reg(REG_ACK_TIMEOUT, to_val);
    rx_stall_pct <= stall_pct;
    if (hold) hold_token <= hold_token + 1;
    send_items(count, idle_pct);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Timing settings, idling mixes and the long hold-off
    run_phase(8'd1,   8'd3,   0,  0,  1'b0, 400);
    run_phase(8'd2,   8'd0,   69, 0,  1'b0, 330);
    run_phase(8'd0,   8'd255, 0,  69, 1'b0, 330);
    run_phase(8'd1,   8'd1,   14, 14, 1'b1, 280);
    write_reg(REG_SPARE_2, 8'hFF);
    write_reg(REG_SPARE_3, 8'h00);
    run_phase(8'd255, 8'd250, 0,  0,  1'b0, 120);
    run_phase(8'd1,   8'd250, 0,  0,  1'b0, 100);

    // Drain, then give a stray result time to show up
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d bus ticks: %0d writes and %0d reads started, %0d ack timeouts",
             sb.ticks, sb.writes, sb.reads, sb.timeouts);
    $display("Timing changed mid-transfer across six settings with gaps, stalls and a long hold-off");
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/i2cmra_pkg.sv
rtl/i2cmra_seq.sv
rtl/i2cmra_obuf.sv
rtl/i2c_master_register_access_core.sv
rtl/i2cmra_checker.sv
tb/sv/tb_top.sv
